[hw/rtl/lrupr_pkg.sv]
// Shared constants and types for the LRU page replacement block.
// No dependencies; imported by the core and the top level.
`timescale 1ns / 1ps

package lrupr_pkg;

	localparam int MAX_FRAMES = 8;
	localparam int PAGE_BITS  = 8;
	localparam int FRAME_W    = $clog2(MAX_FRAMES);
	localparam int CFG_W      = 4;
	localparam int FAULT_W    = 16;

	localparam logic [FAULT_W-1:0] FAULT_MAX = {FAULT_W{1'b1}};
	localparam logic [CFG_W-1:0]   FRAMES_RESET = CFG_W'(MAX_FRAMES);

	// Register indexes of the configuration port.
	localparam logic REG_FRAMES_IN_USE = 1'b0;

	typedef struct packed {
		logic                 hit;
		logic [FRAME_W-1:0]   frame_index;
		logic                 evicted_valid;
		logic [PAGE_BITS-1:0] evicted_page;
		logic [FAULT_W-1:0]   fault_count;
	} lrupr_result_t;

endpackage

[hw/rtl/lrupr_core.sv]
// Frame table, recency ranks and fault counter with the combinational lookup.
// Depends on lrupr_pkg.
`timescale 1ns / 1ps

module lrupr_core
	import lrupr_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic [PAGE_BITS-1:0] page,
	input  logic [CFG_W-1:0]     frames_in_use,
	output lrupr_result_t        res
);

	logic [PAGE_BITS-1:0]  page_q  [MAX_FRAMES];
	logic [MAX_FRAMES-1:0] valid_q;
	logic [FRAME_W-1:0]    rank_q  [MAX_FRAMES];
	logic [FAULT_W-1:0]    faults_q;

	logic [MAX_FRAMES-1:0] act, hit_vec, empty_vec, lru_vec;
	logic                  hit, any_empty;
	logic [FRAME_W-1:0]    f, f_lru, old_rank;
	logic [FRAME_W-1:0]    rank_d  [MAX_FRAMES];
	logic [FAULT_W-1:0]    faults_d;

	function automatic logic [FRAME_W-1:0] first_set(input logic [MAX_FRAMES-1:0] vec);
		logic [FRAME_W-1:0] idx;
		idx = '0;
		for (int k = MAX_FRAMES - 1; k >= 0; k--) begin
			if (vec[k]) idx = FRAME_W'(k);
		end
		return idx;
	endfunction

	always_comb begin
		for (int k = 0; k < MAX_FRAMES; k++) begin
			// Frame 0 always takes part, so a count of zero acts as one.
			act[k]       = (k == 0) || (32'(k) < 32'(frames_in_use));
			hit_vec[k]   = act[k] && valid_q[k] && (page_q[k] == page);
			empty_vec[k] = act[k] && !valid_q[k];
			lru_vec[k]   = act[k];
			for (int j = 0; j < MAX_FRAMES; j++) begin
				if (j != k && act[j] && rank_q[j] < rank_q[k]) lru_vec[k] = 1'b0;
			end
		end
		hit       = |hit_vec;
		any_empty = |empty_vec;
		f_lru     = first_set(lru_vec);
		if (hit) begin
			f = first_set(hit_vec);
		end else if (any_empty) begin
			f = first_set(empty_vec);
		end else begin
			f = f_lru;
		end

		old_rank = rank_q[f];
		for (int k = 0; k < MAX_FRAMES; k++) begin
			if (rank_q[k] > old_rank) rank_d[k] = rank_q[k] - 1'b1;
			else                      rank_d[k] = rank_q[k];
		end
		rank_d[f] = FRAME_W'(MAX_FRAMES - 1);

		if (!hit && faults_q != FAULT_MAX) faults_d = faults_q + 1'b1;
		else                               faults_d = faults_q;

		res.hit           = hit;
		res.frame_index   = f;
		res.evicted_valid = !hit && !any_empty;
		res.evicted_page  = (!hit && !any_empty) ? page_q[f_lru] : '0;
		res.fault_count   = faults_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= '0;
			faults_q <= '0;
			for (int k = 0; k < MAX_FRAMES; k++) rank_q[k] <= FRAME_W'(k);
		end else if (en) begin
			if (!hit) valid_q[f] <= 1'b1;
			faults_q <= faults_d;
			for (int k = 0; k < MAX_FRAMES; k++) rank_q[k] <= rank_d[k];
		end
	end

	// Page tags need no reset: a tag is only compared while its valid bit is set.
	always_ff @(posedge clk) begin
		if (en && !hit) page_q[f] <= page;
	end

endmodule

[hw/rtl/lru_page_replacement.sv]
// Top level of the LRU page replacement block: stream ports, APB register, pipeline.
// Depends on lrupr_pkg and lrupr_core.
`timescale 1ns / 1ps

// Each transaction on the input stream carries one referenced page number and
// produces exactly one result transaction. A page is looked up in the active
// frames (0 .. frames_in_use-1); on a hit that frame becomes most recent, on a
// fault the page fills the lowest empty active frame or replaces the least
// recently used one, and a fault counter saturating at 65535 advances. The
// block accepts one page per clock cycle while the result stream is not
// stalled: the page is held in an input register, the eight tag compares, the
// rank search and the rank update run combinationally behind it, and the
// result lands in the output register. The frame state is updated together
// with the output register, so the next page sees it without a bubble. The
// frames_in_use register sits at byte address 0; a count of zero acts as one and
// counts above eight act as eight. Frames outside the active range keep their
// pages and rejoin with them when the count grows again.

module lru_page_replacement
	import lrupr_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	// Input stream.
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] page
	// Result stream.
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // [0] hit, [3:1] frame_index, [4] evicted_valid,
	                               // [12:5] evicted_page, [28:13] fault_count, rest zero
	// Configuration port.
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	logic [CFG_W-1:0]     frames_q;
	logic                 valid_s1;
	logic [PAGE_BITS-1:0] page_s1;
	logic                 out_valid_q;
	lrupr_result_t        result_q;
	lrupr_result_t        res;
	logic                 advance;

	// Configuration register. Only the low four bits of a write are kept, and
	// addresses with paddr[2] set are ignored, while addresses 0 to 3 all select it.
	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_FRAMES_IN_USE) ? 32'(frames_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frames_q <= FRAMES_RESET;
		end else if (psel && penable && pwrite && pready &&
		             paddr[2] == REG_FRAMES_IN_USE) begin
			frames_q <= pwdata[CFG_W-1:0];
		end
	end

	// The held page moves on whenever the output register is empty or is being
	// emptied in this cycle, and the input register refills in the same cycle.
	assign advance  = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (s_tready) valid_s1 <= s_tvalid;
			if (advance)            out_valid_q <= 1'b1;
			else if (m_tready)      out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) page_s1 <= s_tdata[PAGE_BITS-1:0];
		if (advance)              result_q <= res;
	end

	lrupr_core u_core (
		.clk           (clk),
		.arst_n        (arst_n),
		.en            (advance),
		.page          (page_s1),
		.frames_in_use (frames_q),
		.res           (res)
	);

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {3'b000, result_q.fault_count, result_q.evicted_page,
	                   result_q.evicted_valid, result_q.frame_index, result_q.hit};

endmodule

[hw/rtl/lrupr_checker.sv]
// Port-level checks for the LRU page replacement block, bound to the top level.
// Depends only on the ports of lru_page_replacement.
`timescale 1ns / 1ps

module lrupr_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [31:0] m_tdata
);

	// A stalled result stays in place.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// Input is refused only when a result is waiting and not being taken.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid && !m_tready)
		else $error("input stalled without output back-pressure");

	// A hit never evicts.
	a_hit_no_evict: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(m_tdata[0] && m_tdata[4]))
		else $error("hit reported with eviction");

	// Without an eviction the evicted page reads as zero.
	a_evict_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tdata[4] |-> m_tdata[12:5] == 8'd0)
		else $error("evicted page set without eviction");

endmodule

bind lru_page_replacement lrupr_checker u_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
